// File: design/p2f_pkg.sv
package p2f_pkg;

  localparam int SampleWidth = 64;
  localparam int FloatWidth  = 32;
  localparam int FmtWidth    = 3;

  localparam logic [FmtWidth-1:0] FMT_U8  = 3'd0;
  localparam logic [FmtWidth-1:0] FMT_S16 = 3'd1;
  localparam logic [FmtWidth-1:0] FMT_S32 = 3'd2;
  localparam logic [FmtWidth-1:0] FMT_S64 = 3'd3;
  localparam logic [FmtWidth-1:0] FMT_F32 = 3'd4;
  localparam logic [FmtWidth-1:0] FMT_F64 = 3'd5;
  localparam logic [FmtWidth-1:0] FMT_RESET = FMT_S16;

  // Front-end result handed to the rounding stage.
  typedef struct packed {
    logic        pass;      // result is final, taken from bits
    logic [31:0] bits;      // final pattern when pass is set
    logic        sign;
    logic [63:0] sig;       // nonzero magnitude, value = sig * 2^exp
    logic signed [12:0] exp;
  } p2f_unpk_t;

endpackage

// File: design/p2f_unpack.sv
module p2f_unpack (
  input  logic [p2f_pkg::FmtWidth-1:0]    fmt,
  input  logic [p2f_pkg::SampleWidth-1:0] word,
  output p2f_pkg::p2f_unpk_t              unpk
);
  import p2f_pkg::*;

  logic [63:0] v;
  logic [63:0] mag;
  logic [10:0] dex;
  logic [51:0] man;

  always_comb begin
    unpk      = '0;
    v         = '0;
    dex       = word[62:52];
    man       = word[51:0];
    unpk.exp  = '0;
    unpk.pass = 1'b0;
    unpk.sign = 1'b0;
    case (fmt)
      FMT_U8: begin
        v = {{56{~word[7]}}, ~word[7], word[6:0]};
        unpk.exp = -13'sd7;
      end
      FMT_S16: begin
        v = {{48{word[15]}}, word[15:0]};
        unpk.exp = -13'sd15;
      end
      FMT_S32: begin
        v = {{32{word[31]}}, word[31:0]};
        unpk.exp = -13'sd31;
      end
      FMT_S64: begin
        v = word;
        unpk.exp = -13'sd63;
      end
      FMT_F32: begin
        unpk.pass = 1'b1;
        unpk.bits = word[31:0];
      end
      FMT_F64: begin
        unpk.sign = word[63];
        if (dex == 11'h7FF) begin
          unpk.pass = 1'b1;
          unpk.bits = (man == '0) ? {word[63], 31'h7F800000}
                                  : {word[63], 8'hFF, 1'b1, man[50:29]};
        end else if (dex == '0) begin
          unpk.sig = {12'd0, man};
          unpk.exp = -13'sd1074;
          if (man == '0) begin
            unpk.pass = 1'b1;
            unpk.bits = {word[63], 31'd0};
          end
        end else begin
          unpk.sig = {11'd0, 1'b1, man};
          unpk.exp = $signed({2'b00, dex}) - 13'sd1075;
        end
      end
      default: begin
        unpk.pass = 1'b1;
        unpk.bits = '0;
      end
    endcase
    if (fmt == FMT_U8 || fmt == FMT_S16 || fmt == FMT_S32 || fmt == FMT_S64) begin
      mag = v[63] ? (~v + 64'd1) : v;
      unpk.sign = v[63];
      unpk.sig  = mag;
      if (mag == '0) begin
        unpk.pass = 1'b1;
        unpk.bits = '0;
      end
    end else begin
      mag = '0;
    end
  end

endmodule

// File: design/p2f_round.sv
module p2f_round (
  input  p2f_pkg::p2f_unpk_t               unpk,
  output logic [p2f_pkg::FloatWidth-1:0]   bits
);
  import p2f_pkg::*;

  logic [5:0]         lead;
  logic signed [13:0] lsbexp;
  logic signed [13:0] shift;
  logic [63:0]        q;
  logic [63:0]        rem;
  logic [63:0]        half;
  logic [63:0]        mask;
  logic [6:0]         sh;
  logic [33:0]        total;

  // Leading one position.
  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (unpk.sig[i]) lead = 6'(i);
    end
  end

  always_comb begin
    lsbexp = 14'($signed({8'd0, lead})) + 14'(unpk.exp) - 14'sd23;
    if (lsbexp < -14'sd149) lsbexp = -14'sd149;
    shift = lsbexp - 14'(unpk.exp);
    q    = '0;
    rem  = '0;
    half = '0;
    mask = '0;
    sh   = '0;
    if (shift <= 0) begin
      q = unpk.sig << 6'(-shift);
    end else if (shift <= 14'sd63) begin
      sh   = 7'(shift);
      mask = (64'd1 << sh) - 64'd1;
      half = 64'd1 << (sh - 7'd1);
      rem  = unpk.sig & mask;
      q    = unpk.sig >> sh;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end else if (shift == 14'sd64) begin
      half = 64'h8000_0000_0000_0000;
      if (unpk.sig > half) q = 64'd1;
    end
    total = 34'($unsigned(lsbexp + 14'sd149)) << 23;
    total = total + q[33:0];
    if (total >= 34'h7F800000) total = 34'h7F800000;
    bits = unpk.pass ? unpk.bits : {unpk.sign, total[30:0]};
  end

endmodule

// File: design/pcm_sample_to_float32.sv
// PCM sample to single-precision float converter.
// Input: drive in_sample_word with start high; a beat is taken at any
// rising edge where start is high and busy is low. busy is always low, so
// one sample per clock is accepted.
// Output: once a beat has passed the input register and then the result
// register, out_float_bits holds the IEEE single pattern for one cycle,
// flagged by out_valid. The receiver cannot stall, so results are simply
// streamed; nothing is held back. The throughput is one beat per cycle,
// set by the single combinational pass of unpacking plus rounding between
// the two registers.
// Configuration: cfg_valid/cfg_ready write cfg_sample_format. cfg_ready
// is always high. Change the format only when no beat is in flight.
// Reset (rst_n low, synchronous) clears both valid flags and sets the
// format to signed 16-bit. Unknown formats produce +0.0.
module pcm_sample_to_float32 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [p2f_pkg::SampleWidth-1:0]   in_sample_word,
  output logic                              out_valid,
  output logic [p2f_pkg::FloatWidth-1:0]    out_float_bits,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [p2f_pkg::FmtWidth-1:0]      cfg_sample_format
);
  import p2f_pkg::*;

  logic [FmtWidth-1:0]    fmt_r;
  logic                   in_vld_r;
  logic [SampleWidth-1:0] word_r;
  logic                   out_vld_r;
  logic [FloatWidth-1:0]  res_r;
  logic [FloatWidth-1:0]  res_nxt;
  p2f_unpk_t              unpk;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) fmt_r <= cfg_sample_format;
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    word_r <= in_sample_word;
    res_r  <= res_nxt;
  end

  p2f_unpack u_unpack (
    .fmt  (fmt_r),
    .word (word_r),
    .unpk (unpk)
  );

  p2f_round u_round (
    .unpk (unpk),
    .bits (res_nxt)
  );

  assign out_valid      = out_vld_r;
  assign out_float_bits = res_r;

endmodule

// File: design/p2f_checker.sv
module p2f_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        cfg_ready
);

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("result missing");
  a_spur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2)) else $error("spurious result");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready && !busy) else $error("ports not ready");

endmodule

bind pcm_sample_to_float32 p2f_checker u_p2f_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);

// File: tb/sv/pcm_float_checker.sv
`timescale 1ns / 1ps

module pcm_float_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [p2f_pkg::SampleWidth-1:0] in_sample_word,
  input  logic                            out_valid,
  input  logic [p2f_pkg::FloatWidth-1:0]  out_float_bits,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [p2f_pkg::FmtWidth-1:0]    cfg_sample_format,
  output int                              fail_count,
  output int                              pending_count,
  output int                              checked_count
);
  import p2f_pkg::*;

  logic [FmtWidth-1:0] cur_format;
  logic [31:0]         float_queue[$];

  function automatic logic [31:0] round_mag(logic [63:0] sig, int e);
    int          p;
    int          lsb;
    int          sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    p = 63;
    while (sig[p] == 1'b0) p--;
    lsb = p + e - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - e;
    if (sh <= 0) begin
      q = sig << (-sh);
    end else if (sh > 64) begin
      q = '0;
    end else begin
      rem  = (sh == 64) ? sig : (sig & ((64'd1 << sh) - 64'd1));
      half = 64'd1 << (sh - 1);
      q    = (sh == 64) ? 64'd0 : (sig >> sh);
      if (rem > half || (rem == half && q[0])) q++;
    end
    bits = (64'(lsb + 149) << 23) + q;
    if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
    return bits[31:0];
  endfunction

  function automatic logic [31:0] scale_int(logic [63:0] v, int k);
    logic [63:0] mag;
    mag = v[63] ? (~v + 64'd1) : v;
    if (mag == 0) return 32'd0;
    return {v[63], 31'd0} | round_mag(mag, -k);
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic [31:0] s;
    s = {d[63], 31'd0};
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] == 0) return s | 32'h7F80_0000;
      return s | 32'h7FC0_0000 | 32'(d[51:29]);
    end
    if (d[62:52] == 0) begin
      if (d[51:0] == 0) return s;
      return s | round_mag({12'd0, d[51:0]}, -1074);
    end
    return s | round_mag({11'd1, d[51:0]}, int'(d[62:52]) - 1075);
  endfunction

  function automatic logic [31:0] predict_float(logic [FmtWidth-1:0] f, logic [63:0] w);
    case (f)
      FMT_U8:  return scale_int(64'(w[7:0]) - 64'd128, 7);
      FMT_S16: return scale_int({{48{w[15]}}, w[15:0]}, 15);
      FMT_S32: return scale_int({{32{w[31]}}, w[31:0]}, 31);
      FMT_S64: return scale_int(w, 63);
      FMT_F32: return w[31:0];
      FMT_F64: return narrow_double(w);
      default: return 32'd0;
    endcase
  endfunction

  assign pending_count = float_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_format <= FMT_RESET;
      fail_count <= 0;
      checked_count <= 0;
      float_queue.delete();
    end else begin
      if (out_valid) begin
        if (float_queue.size() == 0) begin
          $error("float_bits: unexpected result, actual %h", out_float_bits);
          fail_count <= fail_count + 1;
        end else begin
          if (float_queue[0] !== out_float_bits) begin
            $error("float_bits: expected %h, actual %h", float_queue[0], out_float_bits);
            fail_count <= fail_count + 1;
          end
          void'(float_queue.pop_front());
          checked_count <= checked_count + 1;
        end
      end
      if (start && !busy) begin
        float_queue.insert(float_queue.size(), predict_float(cur_format, in_sample_word));
      end
      if (cfg_valid && cfg_ready) cur_format <= cfg_sample_format;
    end
  end
endmodule

// File: tb/sv/tb_pcm_sample_to_float32.sv
`timescale 1ns / 1ps

module tb_pcm_sample_to_float32;
  import p2f_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [SampleWidth-1:0] in_sample_word = '0;
  logic                   out_valid;
  logic [FloatWidth-1:0]  out_float_bits;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FmtWidth-1:0]    cfg_sample_format = FMT_RESET;
  int                     fail_count;
  int                     pending_count;
  int                     checked_count;
  int                     cycle_count = 0;

  // This bound is far beyond the length of the whole run.
  localparam int CycleLimit = 200000;

  always #1 clk = ~clk;

  pcm_sample_to_float32 u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_word(in_sample_word), .out_valid(out_valid),
    .out_float_bits(out_float_bits), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_sample_format(cfg_sample_format)
  );

  pcm_float_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_word(in_sample_word), .out_valid(out_valid),
    .out_float_bits(out_float_bits), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_sample_format(cfg_sample_format),
    .fail_count(fail_count), .pending_count(pending_count),
    .checked_count(checked_count)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[pcm_sample_to_float32] ERROR");
      $finish;
    end
  end

  // Hands one sample beat to the block. Start is held high between
  // back-to-back beats, so it is only lowered when a gap follows.
  task automatic send_sample(logic [63:0] w, bit allow_gap);
    int gap;
    start <= 1'b1;
    in_sample_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      in_sample_word <= {$urandom, $urandom};
      gap = $urandom_range(1, 18);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every predicted result has been checked, then lets the
  // two-stage pipeline drain before anything else happens. Start is
  // lowered at once so the last beat is not taken a second time.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Formats are only changed with the pipeline empty.
  task automatic write_format(logic [FmtWidth-1:0] f);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_sample_format <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random doubles cover every exponent band: overflow, the float normal
  // range, the subnormal and underflow band, zeros, infinities and NaNs.
  function automatic logic [63:0] random_double();
    logic [63:0] d;
    logic [10:0] ex;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: ex = 11'(1023 - 126 + $urandom_range(0, 253));
      1: ex = 11'(1023 - 160 + $urandom_range(0, 40));
      2: ex = 11'(1023 + $urandom_range(120, 140));
      3: ex = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      default: ex = d[62:52];
    endcase
    d[62:52] = ex;
    if ($urandom_range(0, 9) == 0) d[51:0] = '0;
    if ($urandom_range(0, 9) == 0) d[28:0] = {1'b1, 28'd0};
    return d;
  endfunction

  function automatic logic [63:0] random_sample(logic [FmtWidth-1:0] f);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (f == FMT_F64) return random_double();
    // Small magnitudes exercise the many-bit shifts of the integer paths.
    if ($urandom_range(0, 5) == 0) w = w >> $urandom_range(0, 63);
    if ($urandom_range(0, 5) == 0) w = ~(w >> $urandom_range(0, 63));
    return w;
  endfunction

  logic [FmtWidth-1:0] fmt;
  bit                  calm;

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats, first at the reset format of signed 16-bit.
    send_sample(64'h0, 0);
    send_sample(64'h7FFF, 0);
    send_sample(64'h8000, 0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 0);
    write_format(FMT_U8);
    send_sample(64'h00, 0);
    send_sample(64'h80, 0);
    send_sample(64'hFF, 0);
    write_format(FMT_S32);
    send_sample(64'h8000_0000, 0);
    send_sample(64'h7FFF_FFFF, 0);
    write_format(FMT_S64);
    send_sample(64'h8000_0000_0000_0000, 0);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 0);
    send_sample(64'h1, 0);
    write_format(FMT_F32);
    send_sample(64'hFFFF_FFFF_7FC0_0001, 0);
    write_format(FMT_F64);
    send_sample(64'h8000_0000_0000_0000, 0);  // negative zero keeps its sign
    send_sample(64'hFFF0_0000_0000_0000, 0);  // negative infinity
    send_sample(64'h7FF0_0000_2000_0001, 0);  // signaling NaN becomes quiet
    send_sample(64'h47F0_0000_0000_0000, 0);  // overflows to infinity
    send_sample(64'h3690_0000_0000_0000, 0);  // below the smallest subnormal
    send_sample(64'h0000_0000_0000_0001, 0);  // double subnormal underflows
    send_sample(64'h380F_FFFF_FFFF_FFFF, 0);  // rounds up to the smallest float normal
    write_format(3'd6);
    send_sample(64'hDEAD_BEEF_0123_4567, 0);  // unknown formats give +0.0
    write_format(3'd7);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 0);

    // Random phases: first each known format in turn, then random formats; the last phases have no gaps.
    for (int ph = 0; ph < 34; ph++) begin
      fmt = (ph < 6) ? 3'(ph) : 3'($urandom_range(0, 7));
      calm = (ph >= 30);
      write_format(fmt);
      for (int n = 0; n < 50; n++) send_sample(random_sample(fmt), !calm);
      // Hold off once mid-run until the pipeline is completely empty.
      if (ph == 15) drain_results();
    end

    drain_results();
    $display("Checked %0d results over all six formats and the two unknown codes,",
             checked_count);
    $display("including zeros, infinities, NaNs, overflow and subnormal narrowing.");
    if (fail_count == 0) begin
      $display("[pcm_sample_to_float32] OK");
    end else begin
      $display("[pcm_sample_to_float32] ERROR");
    end
    $finish;
  end
endmodule
